@@ hdl/qmp_pkg.sv @@
`default_nettype none
package qmp_pkg;

  localparam int VALUE_W       = 32;
  localparam int FRAC_BITS     = 24;
  localparam int CORDIC_STAGES = 24;
  localparam int ANG_BITS      = 60;
  localparam int COEF_BITS     = 28;
  localparam int STORE_DEPTH   = 22;
  localparam int RESULT_COUNT  = 13;
  localparam int WIDEN_SHIFT   = ANG_BITS - 2 * FRAC_BITS - 1;
  localparam int STAGE_W       = $clog2(CORDIC_STAGES);

  localparam logic [1:0] CFG_SAMPLE_TIME = 2'd0;
  localparam logic [1:0] CFG_ADD_NOISE   = 2'd1;

  localparam logic [23:0] SAMPLE_TIME_RST = 24'd1677722;

  typedef struct packed {
    logic [4:0]         component_index;
    logic signed [31:0] component_value;
    logic               last_component;
  } comp_in_t;

  typedef struct packed {
    logic [3:0]         result_index;
    logic signed [31:0] result_value;
    logic               result_last;
  } comp_out_t;

  typedef logic signed [63:0] angle_tab_t [CORDIC_STAGES];

  // Coefficient selects for the quaternion product terms.
  localparam logic [1:0] SEL_COS = 2'd0;
  localparam logic [1:0] SEL_SX  = 2'd1;
  localparam logic [1:0] SEL_SY  = 2'd2;
  localparam logic [1:0] SEL_SZ  = 2'd3;

  // Each term is {coefficient select, negate, quaternion component}, four terms per row.
  localparam logic [4:0] QTERM [16] = '{
    {SEL_COS, 1'b0, 2'd0}, {SEL_SX, 1'b1, 2'd1}, {SEL_SY, 1'b1, 2'd2}, {SEL_SZ, 1'b1, 2'd3},
    {SEL_COS, 1'b0, 2'd1}, {SEL_SX, 1'b0, 2'd0}, {SEL_SZ, 1'b1, 2'd2}, {SEL_SY, 1'b0, 2'd3},
    {SEL_COS, 1'b0, 2'd2}, {SEL_SY, 1'b0, 2'd0}, {SEL_SZ, 1'b0, 2'd1}, {SEL_SX, 1'b1, 2'd3},
    {SEL_COS, 1'b0, 2'd3}, {SEL_SZ, 1'b0, 2'd0}, {SEL_SY, 1'b1, 2'd1}, {SEL_SX, 1'b0, 2'd2}
  };

  function automatic logic [127:0] udiv_const(input logic [127:0] num, input logic [127:0] den);
    logic [127:0] rem;
    logic [127:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[126:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic signed [63:0] atan_recip(input logic [63:0] n);
    logic [127:0]       p;
    logic [127:0]       t;
    logic signed [63:0] sum;
    p   = udiv_const(128'd1 << ANG_BITS, {64'd0, n});
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != '0) begin
        t = udiv_const(p, 128'(2 * k + 1));
        if (k[0]) begin
          sum = sum - $signed(t[63:0]);
        end else begin
          sum = sum + $signed(t[63:0]);
        end
        p = udiv_const(udiv_const(p, {64'd0, n}), {64'd0, n});
      end
    end
    return sum;
  endfunction

  function automatic angle_tab_t make_angles();
    angle_tab_t tab;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (i == 0) begin
        tab[i] = atan_recip(64'd2) + atan_recip(64'd3);
      end else begin
        tab[i] = atan_recip(64'd1 << i);
      end
    end
    return tab;
  endfunction

  function automatic logic signed [63:0] cordic_x0();
    logic [127:0] g;
    logic [127:0] q;
    g = 128'd1 << ANG_BITS;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (2 * i < 64) begin
        g = g + (g >> (2 * i));
      end
    end
    q = udiv_const(128'd1 << (2 * ANG_BITS), g);
    return $signed(q[63:0]);
  endfunction

  function automatic logic signed [63:0] pi_scaled();
    logic signed [63:0] a;
    a = atan_recip(64'd2) + atan_recip(64'd3);
    return (a <<< 2) >>> WIDEN_SHIFT;
  endfunction

  localparam angle_tab_t         CORDIC_ANGLE = make_angles();
  localparam logic signed [63:0] CORDIC_X0    = cordic_x0();
  localparam logic signed [63:0] PI_A         = pi_scaled();
  localparam logic signed [63:0] TWO_PI_A     = PI_A <<< 1;

  localparam logic signed [69:0] SAT_HI = 70'sd2147483647;
  localparam logic signed [69:0] SAT_LO = -70'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [69:0] x);
    logic signed [31:0] r;
    if (x > SAT_HI) begin
      r = 32'h7FFFFFFF;
    end else if (x < SAT_LO) begin
      r = 32'h80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/quaternion_motion_propagate.sv @@
`default_nettype none
// Filter state components are loaded one per request, one request per cycle while idle, into a
// 22-entry store; a request flagged last starts propagation and the block then takes no
// input until the 13 results have been delivered in index order. Propagation runs on one
// shared 36x33 multiplier, a 32-step square root, a 48-step CORDIC (two micro-rotations
// per stage), a 62-step divider and a short angle reduction loop. At zero rate the divider
// is skipped.
module quaternion_motion_propagate import qmp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire comp_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output comp_out_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_A_RD0   = 5'd1;
  localparam logic [4:0] ST_A_RD1   = 5'd2;
  localparam logic [4:0] ST_A_NOISE = 5'd3;
  localparam logic [4:0] ST_A_MUL   = 5'd4;
  localparam logic [4:0] ST_A_RND   = 5'd5;
  localparam logic [4:0] ST_A_SAT   = 5'd6;
  localparam logic [4:0] ST_B_RD    = 5'd7;
  localparam logic [4:0] ST_B_MUL   = 5'd8;
  localparam logic [4:0] ST_B_ACC   = 5'd9;
  localparam logic [4:0] ST_SQ_INIT = 5'd10;
  localparam logic [4:0] ST_SQRT    = 5'd11;
  localparam logic [4:0] ST_D_MUL   = 5'd12;
  localparam logic [4:0] ST_D_LOAD  = 5'd13;
  localparam logic [4:0] ST_D_MOD   = 5'd14;
  localparam logic [4:0] ST_C_START = 5'd15;
  localparam logic [4:0] ST_C_WAIT  = 5'd16;
  localparam logic [4:0] ST_DIV     = 5'd17;
  localparam logic [4:0] ST_DIV_END = 5'd18;
  localparam logic [4:0] ST_G_RD    = 5'd19;
  localparam logic [4:0] ST_G_HI    = 5'd20;
  localparam logic [4:0] ST_G_LO    = 5'd21;
  localparam logic [4:0] ST_G_ACC   = 5'd22;
  localparam logic [4:0] ST_G_RND   = 5'd23;
  localparam logic [4:0] ST_H_RD    = 5'd24;
  localparam logic [4:0] ST_H_MUL   = 5'd25;
  localparam logic [4:0] ST_H_ACC   = 5'd26;
  localparam logic [4:0] ST_H_SAT   = 5'd27;
  localparam logic [4:0] ST_OUT     = 5'd28;

  logic [23:0] sample_time_r;
  logic        add_noise_r;

  logic [4:0]         state_r, state_nxt;
  logic [3:0]         k_r, k_nxt;
  logic [1:0]         t_r, t_nxt;
  logic [5:0]         it_r, it_nxt;
  logic signed [69:0] acc_r, acc_nxt;
  logic [63:0]        sv_r, sv_nxt, sres_r, sres_nxt, sbit_r, sbit_nxt;
  logic signed [63:0] th_r, th_nxt;
  logic [61:0]        dv_r, dv_nxt;
  logic [32:0]        rem_r, rem_nxt;
  logic               neg_r, neg_nxt;
  logic signed [62:0] fac_r, fac_nxt;

  logic [31:0]        res_r [RESULT_COUNT];
  logic signed [35:0] coef_r [4];
  logic               res_we, coef_we;
  logic [3:0]         res_waddr;
  logic [1:0]         coef_waddr;
  logic signed [31:0] res_wdata;
  logic signed [35:0] coef_wdata;

  logic [4:0]         rd_addr;
  logic [31:0]        rd_data;
  logic signed [31:0] rd_s;
  logic signed [32:0] rd_abs;
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [68:0] mul_p;
  logic signed [69:0] p_ext, p_rnd24, acc_rnd28, sw_rnd;
  logic               cor_start, cor_done;
  logic signed [63:0] cor_z, cor_cos, cor_sin, s_abs, cos_rnd;
  logic [31:0]        n_val;
  logic [64:0]        sq_sum;
  logic [33:0]        rem_sh;
  logic [4:0]         qterm;
  logic               store_we;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_time_r <= SAMPLE_TIME_RST;
      add_noise_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SAMPLE_TIME: sample_time_r <= cfg_data;
        CFG_ADD_NOISE:   add_noise_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign store_we = in_valid && in_ready && (in_data.component_index < 5'(STORE_DEPTH));

  qmp_store u_store (
    .clk       (clk),
    .wr_en     (store_we),
    .wr_addr   (in_data.component_index),
    .wr_data   (in_data.component_value),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  qmp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign cor_z = th_r <<< WIDEN_SHIFT;

  qmp_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .z_in    (cor_z),
    .done    (cor_done),
    .cos_out (cor_cos),
    .sin_out (cor_sin)
  );

  assign rd_s      = $signed(rd_data);
  assign rd_abs    = rd_s[31] ? -33'(rd_s) : 33'(rd_s);
  assign p_ext     = 70'(mul_p);
  assign p_rnd24   = (p_ext + 70'sd8388608) >>> FRAC_BITS;
  assign acc_rnd28 = (acc_r + 70'sd134217728) >>> COEF_BITS;
  assign sw_rnd    = (acc_r + 70'sd2147483648) >>> 32;
  assign cos_rnd   = (cor_cos + 64'sd2147483648) >>> 32;
  assign s_abs     = cor_sin[63] ? -cor_sin : cor_sin;
  assign n_val     = sres_r[31:0];
  assign sq_sum    = {1'b0, sres_r} + {1'b0, sbit_r};
  assign rem_sh    = {rem_r, dv_r[61]};
  assign qterm     = QTERM[{k_r[1:0], t_r}];

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    t_nxt      = t_r;
    it_nxt     = it_r;
    acc_nxt    = acc_r;
    sv_nxt     = sv_r;
    sres_nxt   = sres_r;
    sbit_nxt   = sbit_r;
    th_nxt     = th_r;
    dv_nxt     = dv_r;
    rem_nxt    = rem_r;
    neg_nxt    = neg_r;
    fac_nxt    = fac_r;
    rd_addr    = '0;
    mul_a      = '0;
    mul_b      = '0;
    cor_start  = 1'b0;
    res_we     = 1'b0;
    res_waddr  = k_r;
    res_wdata  = sat32(acc_r);
    coef_we    = 1'b0;
    coef_waddr = SEL_COS;
    coef_wdata = 36'(cos_rnd);
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_data.last_component) begin
          k_nxt     = '0;
          state_nxt = ST_A_RD0;
        end
      end
      ST_A_RD0: begin
        rd_addr   = 5'(k_r);
        state_nxt = ST_A_RD1;
      end
      ST_A_RD1: begin
        acc_nxt   = 70'(rd_s);
        rd_addr   = 5'(k_r) + 5'd13;
        state_nxt = ST_A_NOISE;
      end
      ST_A_NOISE: begin
        if (add_noise_r) begin
          acc_nxt = acc_r + 70'(rd_s);
        end
        rd_addr   = 5'(k_r) - 5'd6;
        state_nxt = (k_r >= 4'd6) ? ST_A_MUL : ST_A_SAT;
      end
      ST_A_MUL: begin
        mul_a     = 36'(rd_s);
        mul_b     = $signed({9'd0, sample_time_r});
        state_nxt = ST_A_RND;
      end
      ST_A_RND: begin
        acc_nxt   = acc_r + p_rnd24;
        state_nxt = ST_A_SAT;
      end
      ST_A_SAT: begin
        res_we = 1'b1;
        if (k_r == 4'd8) begin
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = ST_B_RD;
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = ST_A_RD0;
        end
      end
      ST_B_RD: begin
        rd_addr   = 5'(k_r) + 5'd3;
        state_nxt = ST_B_MUL;
      end
      ST_B_MUL: begin
        mul_a     = 36'(rd_abs);
        mul_b     = rd_abs;
        state_nxt = ST_B_ACC;
      end
      ST_B_ACC: begin
        acc_nxt = acc_r + p_ext;
        if (k_r == 4'd2) begin
          state_nxt = ST_SQ_INIT;
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = ST_B_RD;
        end
      end
      ST_SQ_INIT: begin
        sv_nxt    = acc_r[63:0];
        sres_nxt  = '0;
        sbit_nxt  = 64'd1 << 62;
        it_nxt    = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if ({1'b0, sv_r} >= sq_sum) begin
          sv_nxt   = sv_r - sq_sum[63:0];
          sres_nxt = (sres_r >> 1) + sbit_r;
        end else begin
          sres_nxt = sres_r >> 1;
        end
        sbit_nxt = sbit_r >> 2;
        it_nxt   = it_r + 6'd1;
        if (it_r == 6'd31) begin
          state_nxt = ST_D_MUL;
        end
      end
      ST_D_MUL: begin
        mul_a     = $signed({4'd0, n_val});
        mul_b     = $signed({9'd0, sample_time_r});
        state_nxt = ST_D_LOAD;
      end
      ST_D_LOAD: begin
        th_nxt    = mul_p[63:0];
        state_nxt = ST_D_MOD;
      end
      ST_D_MOD: begin
        if (th_r >= TWO_PI_A) begin
          th_nxt = th_r - TWO_PI_A;
        end else begin
          if (th_r > PI_A) begin
            th_nxt = th_r - TWO_PI_A;
          end
          state_nxt = ST_C_START;
        end
      end
      ST_C_START: begin
        cor_start = 1'b1;
        state_nxt = ST_C_WAIT;
      end
      ST_C_WAIT: begin
        if (cor_done) begin
          coef_we = 1'b1;
          k_nxt   = '0;
          if (n_val == '0) begin
            fac_nxt   = $signed(63'(sample_time_r) << WIDEN_SHIFT);
            state_nxt = ST_G_RD;
          end else begin
            dv_nxt    = s_abs[61:0] + 62'(n_val >> 1);
            rem_nxt   = '0;
            neg_nxt   = cor_sin[63];
            it_nxt    = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (rem_sh >= {2'b00, n_val}) begin
          rem_nxt = 33'(rem_sh - {2'b00, n_val});
          dv_nxt  = {dv_r[60:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[32:0];
          dv_nxt  = {dv_r[60:0], 1'b0};
        end
        it_nxt = it_r + 6'd1;
        if (it_r == 6'd61) begin
          state_nxt = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        fac_nxt   = neg_r ? -$signed(63'(dv_r)) : $signed(63'(dv_r));
        state_nxt = ST_G_RD;
      end
      ST_G_RD: begin
        rd_addr   = 5'(k_r) + 5'd3;
        state_nxt = ST_G_HI;
      end
      ST_G_HI: begin
        rd_addr   = 5'(k_r) + 5'd3;
        mul_a     = 36'($signed(fac_r[62:31]));
        mul_b     = 33'(rd_s);
        state_nxt = ST_G_LO;
      end
      ST_G_LO: begin
        rd_addr   = 5'(k_r) + 5'd3;
        acc_nxt   = p_ext <<< 31;
        mul_a     = $signed({5'd0, fac_r[30:0]});
        mul_b     = 33'(rd_s);
        state_nxt = ST_G_ACC;
      end
      ST_G_ACC: begin
        acc_nxt   = acc_r + p_ext;
        state_nxt = ST_G_RND;
      end
      ST_G_RND: begin
        coef_we    = 1'b1;
        coef_waddr = k_r[1:0] + 2'd1;
        coef_wdata = 36'(sw_rnd);
        if (k_r == 4'd2) begin
          k_nxt     = '0;
          t_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = ST_H_RD;
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = ST_G_RD;
        end
      end
      ST_H_RD: begin
        rd_addr   = 5'd9 + 5'(qterm[1:0]);
        state_nxt = ST_H_MUL;
      end
      ST_H_MUL: begin
        rd_addr   = 5'd9 + 5'(qterm[1:0]);
        mul_a     = coef_r[qterm[4:3]];
        mul_b     = 33'(rd_s);
        state_nxt = ST_H_ACC;
      end
      ST_H_ACC: begin
        acc_nxt   = qterm[2] ? acc_r - p_ext : acc_r + p_ext;
        t_nxt     = t_r + 2'd1;
        state_nxt = (t_r == 2'd3) ? ST_H_SAT : ST_H_RD;
      end
      ST_H_SAT: begin
        res_we    = 1'b1;
        res_waddr = 4'd9 + k_r;
        res_wdata = sat32(acc_rnd28);
        acc_nxt   = '0;
        if (k_r == 4'd3) begin
          k_nxt     = '0;
          state_nxt = ST_OUT;
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = ST_H_RD;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          if (k_r == 4'(RESULT_COUNT - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + 4'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      t_r     <= '0;
      it_r    <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      t_r     <= t_nxt;
      it_r    <= it_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    sv_r   <= sv_nxt;
    sres_r <= sres_nxt;
    sbit_r <= sbit_nxt;
    th_r   <= th_nxt;
    dv_r   <= dv_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    fac_r  <= fac_nxt;
    if (res_we) begin
      res_r[res_waddr] <= res_wdata;
    end
    if (coef_we) begin
      coef_r[coef_waddr] <= coef_wdata;
    end
  end

  assign out_valid             = (state_r == ST_OUT);
  assign out_data.result_index = k_r;
  assign out_data.result_value = $signed(res_r[k_r]);
  assign out_data.result_last  = (k_r == 4'(RESULT_COUNT - 1));

endmodule
`default_nettype wire

@@ hdl/qmp_store.sv @@
`default_nettype none
module qmp_store import qmp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        wr_en,
  input  wire logic [4:0]  wr_addr,
  input  wire logic [31:0] wr_data,
  input  wire logic [4:0]  rd_addr,
  output logic      [31:0] rd_data_r
);

  logic [31:0] mem_r [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

@@ hdl/qmp_mul.sv @@
`default_nettype none
module qmp_mul import qmp_pkg::*; (
  input  wire logic               clk,
  input  wire logic signed [35:0] a,
  input  wire logic signed [32:0] b,
  output logic      signed [68:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= 69'(a) * 69'(b);
  end

endmodule
`default_nettype wire

@@ hdl/qmp_cordic.sv @@
`default_nettype none
module qmp_cordic import qmp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] z_in,
  output logic                    done,
  output logic      signed [63:0] cos_out,
  output logic      signed [63:0] sin_out
);

  logic signed [63:0] x_r, y_r, z_r;
  logic [STAGE_W-1:0] stage_r;
  logic               rep_r, busy_r, done_r;
  logic               up;
  logic signed [63:0] dx, dy, ang2;

  assign up   = !z_r[63];
  assign dx   = y_r >>> stage_r;
  assign dy   = x_r >>> stage_r;
  assign ang2 = CORDIC_ANGLE[stage_r] <<< 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      rep_r   <= 1'b0;
      stage_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        rep_r   <= 1'b0;
        stage_r <= '0;
      end else if (busy_r) begin
        rep_r <= ~rep_r;
        if (rep_r) begin
          if (stage_r == STAGE_W'(CORDIC_STAGES - 1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            stage_r <= stage_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= CORDIC_X0;
      y_r <= '0;
      z_r <= z_in;
    end else if (busy_r) begin
      x_r <= up ? x_r - dx : x_r + dx;
      y_r <= up ? y_r + dy : y_r - dy;
      if (rep_r) begin
        z_r <= up ? z_r - ang2 : z_r + ang2;
      end
    end
  end

  assign done    = done_r;
  assign cos_out = x_r;
  assign sin_out = y_r;

endmodule
`default_nettype wire

@@ sim/tb_quaternion_motion_propagate.sv @@
`timescale 1ns / 1ps
module tb_quaternion_motion_propagate;
  import qmp_pkg::*;

  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;
  localparam int LONG_HOLD = 900;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  comp_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  comp_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  quaternion_motion_propagate dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [31:0] slot_val [STORE_DEPTH];
  logic [23:0] period_q24;
  logic        noise_on;
  longint      stage_ang [CORDIC_STAGES];
  longint      rot_x0;
  longint      pi_q49;

  comp_out_t   state_expect_q [$];
  int          errors;
  int          items_sent;
  int          results_seen;
  int          propagations;
  bit          quiet;
  bit          long_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("quaternion_motion_propagate: mismatch");
    $finish;
  end

  function automatic longint atan_inv(longint unsigned d);
    longint unsigned p;
    longint unsigned t;
    longint          sum;
    int              k;
    p   = (64'd1 << 60) / d;
    sum = 0;
    k   = 0;
    while (p != 0) begin
      t = p / (2 * k + 1);
      if (k % 2 == 1) begin
        sum = sum - longint'(t);
      end else begin
        sum = sum + longint'(t);
      end
      p = p / d / d;
      k++;
    end
    return sum;
  endfunction

  function automatic void build_rotation_tables();
    longint unsigned g;
    logic [127:0]    q;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      stage_ang[i] = (i == 0) ? atan_inv(2) + atan_inv(3) : atan_inv(64'd1 << i);
    end
    g = 64'd1 << 60;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (2 * i < 64) begin
        g = g + (g >> (2 * i));
      end
    end
    q      = (128'd1 << 120) / {64'd0, g};
    rot_x0 = longint'(q[63:0]);
    pi_q49 = (4 * (atan_inv(2) + atan_inv(3))) >>> WIDEN_SHIFT;
  endfunction

  function automatic longint round_shift(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) begin
      return 32'h7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      return 32'h80000000;
    end
    return x[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) begin
      b = b >> 2;
    end
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint div_near(longint a, longint unsigned b);
    longint unsigned ua;
    longint unsigned mq;
    ua = (a < 0) ? longint'(-a) : a;
    mq = (ua + b / 2) / b;
    return (a < 0) ? -longint'(mq) : longint'(mq);
  endfunction

  function automatic void rotate(longint z, output longint c, output longint s);
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     up;
    x = rot_x0;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      up = (z >= 0);
      for (int rep = 0; rep < 2; rep++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (up) begin
          x = x - dx;
          y = y + dy;
        end else begin
          x = x + dx;
          y = y - dy;
        end
      end
      z = up ? z - 2 * stage_ang[i] : z + 2 * stage_ang[i];
    end
    c = x;
    s = y;
  endfunction

  function automatic void predict_propagation();
    longint          v [STORE_DEPTH];
    longint          sw [3];
    longint          acc [4];
    logic [31:0]     rv [RESULT_COUNT];
    longint          t;
    longint          r;
    longint          th;
    longint          c60;
    longint          s60;
    longint          fac;
    longint          cq;
    longint unsigned sq;
    longint unsigned m;
    longint unsigned n;
    comp_out_t       e;
    for (int k = 0; k < STORE_DEPTH; k++) begin
      v[k] = longint'($signed(slot_val[k]));
    end
    t = longint'({40'd0, period_q24});
    for (int k = 0; k < 9; k++) begin
      r = v[k] + (noise_on ? v[13 + k] : 0);
      if (k >= 6) begin
        r = r + round_shift(v[k - 6] * t, FRAC_BITS);
      end
      rv[k] = clamp32(r);
    end
    sq = 0;
    for (int k = 3; k < 6; k++) begin
      m  = (v[k] < 0) ? -v[k] : v[k];
      sq = sq + m * m;
    end
    n  = int_sqrt(sq);
    th = longint'(n) * t;
    th = th % (2 * pi_q49);
    if (th > pi_q49) begin
      th = th - 2 * pi_q49;
    end
    rotate(th <<< WIDEN_SHIFT, c60, s60);
    fac = (n != 0) ? div_near(s60, n) : (t <<< WIDEN_SHIFT);
    for (int k = 0; k < 3; k++) begin
      sw[k] = round_shift(fac * v[3 + k], ANG_BITS - COEF_BITS);
    end
    cq = round_shift(c60, ANG_BITS - COEF_BITS);
    acc[0] = cq * v[9] - sw[0] * v[10] - sw[1] * v[11] - sw[2] * v[12];
    acc[1] = cq * v[10] + sw[0] * v[9] - sw[2] * v[11] + sw[1] * v[12];
    acc[2] = cq * v[11] + sw[1] * v[9] + sw[2] * v[10] - sw[0] * v[12];
    acc[3] = cq * v[12] + sw[2] * v[9] - sw[1] * v[10] + sw[0] * v[11];
    for (int k = 0; k < 4; k++) begin
      rv[9 + k] = clamp32(round_shift(acc[k], COEF_BITS));
    end
    for (int k = 0; k < RESULT_COUNT; k++) begin
      e.result_index = k[3:0];
      e.result_value = rv[k];
      e.result_last  = (k == RESULT_COUNT - 1);
      state_expect_q.push_back(e);
    end
    propagations++;
  endfunction

  task automatic send_component(input logic [4:0] idx, input logic [31:0] val,
                                input logic last);
    int gap;
    bit r;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{component_index: idx, component_value: val, last_component: last};
    do begin
      @(negedge clk);
      r = in_ready;
      @(posedge clk);
    end while (!r);
    items_sent++;
    if (idx < STORE_DEPTH) begin
      slot_val[idx] = val;
    end
    if (last) begin
      predict_propagation();
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (state_expect_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [23:0] val);
    bit r;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      r = cfg_ready;
      @(posedge clk);
    end while (!r);
    if (idx == CFG_SAMPLE_TIME) begin
      period_q24 = val;
    end else if (idx == CFG_ADD_NOISE) begin
      noise_on = val[0];
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'h01000000;
      4, 5: return 32'($signed($urandom_range(0, 32'h07FFFFFF)) - 32'sh04000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic load_state(input logic [31:0] base, input logic [31:0] rate,
                            input logic [31:0] noise);
    for (int k = 0; k < STORE_DEPTH; k++) begin
      if (k >= 3 && k <= 5) begin
        send_component(k[4:0], rate, 1'b0);
      end else if (k == 9) begin
        send_component(k[4:0], 32'h01000000, 1'b0);
      end else if (k >= 13) begin
        send_component(k[4:0], noise, 1'b0);
      end else begin
        send_component(k[4:0], base, 1'b0);
      end
    end
  endtask

  task automatic test_extremes();
    load_state(32'h7FFFFFFF, 32'h00800000, 32'h7FFFFFFF);
    send_component(5'd12, 32'h80000000, 1'b1);
    wait_idle();
    write_register(CFG_SAMPLE_TIME, 24'hFFFFFF);
    write_register(CFG_ADD_NOISE, 24'd1);
    send_component(5'd0, 32'h80000000, 1'b0);
    send_component(5'd13, 32'h80000000, 1'b1);
  endtask

  task automatic test_zero_rate();
    wait_idle();
    write_register(CFG_SAMPLE_TIME, 24'd0);
    send_component(5'd3, 32'h0, 1'b0);
    send_component(5'd4, 32'h0, 1'b0);
    send_component(5'd5, 32'h0, 1'b1);
    wait_idle();
    write_register(CFG_SAMPLE_TIME, 24'hFFFFFF);
    send_component(5'd10, 32'h00400000, 1'b1);
  endtask

  task automatic test_unused_slot();
    wait_idle();
    write_register(CFG_SPARE_A, 24'hFFFFFF);
    write_register(CFG_SPARE_B, 24'h000000);
    write_register(CFG_ADD_NOISE, 24'hFFFFFE);
    send_component(5'd22, 32'h12345678, 1'b0);
    send_component(5'd31, 32'hFFFFFFFF, 1'b1);
  endtask

  task automatic test_random(input int budget);
    int n;
    int start;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(0, 5) == 0) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0: write_register(CFG_SAMPLE_TIME, 24'd0);
          1: write_register(CFG_SAMPLE_TIME, 24'hFFFFFF);
          default: write_register(CFG_SAMPLE_TIME, 24'($urandom));
        endcase
        write_register(CFG_ADD_NOISE, 24'($urandom_range(0, 1)));
      end
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_component(5'($urandom_range(22, 31)), $urandom, 1'b0);
        end else begin
          send_component(5'($urandom_range(0, 21)), pick_value(), 1'b0);
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        send_component(5'($urandom_range(22, 31)), $urandom, 1'b1);
      end else begin
        send_component(5'($urandom_range(0, 21)), pick_value(), 1'b1);
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_output_stall();
    wait_idle();
    long_hold = 1'b1;
    quiet     = 1'b1;
    send_component(5'd4, 32'hFF000000, 1'b1);
    for (int k = 0; k < 6; k++) begin
      send_component(5'(k), pick_value(), 1'b0);
    end
    send_component(5'd11, pick_value(), 1'b1);
    quiet = 1'b0;
  endtask

  initial begin
    bit r;
    bit h;
    int w;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        w = quiet ? 0 : $urandom_range(0, 14);
        if (w > 0) begin
          out_ready <= 1'b0;
          repeat (w) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        r = out_valid;
        h = long_hold;
        @(posedge clk);
      end while (!r && !h);
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    comp_out_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (state_expect_q.size() == 0) begin
        report_mismatch("unexpected result index", out_data.result_index, 0);
      end else begin
        e = state_expect_q.pop_front();
        if (out_data.result_index !== e.result_index) begin
          report_mismatch("result_index", out_data.result_index, e.result_index);
        end
        if (out_data.result_value !== e.result_value) begin
          report_mismatch("result_value", out_data.result_value, e.result_value);
        end
        if (out_data.result_last !== e.result_last) begin
          report_mismatch("result_last", out_data.result_last, e.result_last);
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_SAMPLE_TIME;
    cfg_data   = '0;
    errors     = 0;
    items_sent = 0;
    results_seen = 0;
    propagations = 0;
    quiet      = 1'b0;
    long_hold  = 1'b0;
    period_q24 = SAMPLE_TIME_RST;
    noise_on   = 1'b0;
    for (int k = 0; k < STORE_DEPTH; k++) begin
      slot_val[k] = '0;
    end
    build_rotation_tables();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_zero_rate();
    test_unused_slot();
    test_random(92);
    test_output_stall();
    wait_idle();
    if (state_expect_q.size() != 0) begin
      errors++;
    end
    $display("Sent %0d components over %0d propagations and checked %0d results,",
             items_sent, propagations, results_seen);
    $display("covering period extremes, noise on and off, zero rate and a long output stall.");
    if (errors == 0) begin
      $display("quaternion_motion_propagate: match");
    end else begin
      $display("quaternion_motion_propagate: mismatch");
    end
    $finish;
  end

endmodule
